### rtl/blp_pkg.sv
package blp_pkg;

    localparam logic [1:0] ST_SUCCESS = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    localparam logic [1:0] ERR_NONE   = 2'd0;

    localparam logic [7:0] CHAR_TERM  = 8'h00;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF    = 8'h66;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] CHAR_X     = 8'h78;

    localparam logic [4:0] BASE_DEC   = 5'd10;
    localparam logic [4:0] BASE_HEX   = 5'd16;
    localparam logic [4:0] NOT_DIGIT  = 5'd16;

    localparam logic [1:0] COUNT_MAX  = 2'd2;
    localparam logic [11:0] BYTE_MAX  = 12'd255;

    typedef struct packed {
        logic [1:0] char_count;
        logic       hex_mode;
        logic       digits_seen;
        logic [7:0] accumulator;
        logic [1:0] first_error;
    } parse_state_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic [1:0] status;
    } result_t;

    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [4:0] d;
        d = NOT_DIGIT;
        if (c >= CHAR_0 && c <= CHAR_9)
        begin
            d = 5'(c - CHAR_0);
        end
        else if (c >= CHAR_LA && c <= CHAR_LF)
        begin
            d = 5'(c - CHAR_LA) + 5'd10;
        end
        else if (c >= CHAR_UA && c <= CHAR_UF)
        begin
            d = 5'(c - CHAR_UA) + 5'd10;
        end
        return d;
    endfunction

endpackage

### rtl/blp_step.sv
module blp_step (
    input  blp_pkg::parse_state_t cur,
    input  logic [7:0]            character,
    output blp_pkg::parse_state_t nxt,
    output blp_pkg::result_t      result,
    output logic                  is_term
);
    import blp_pkg::*;

    logic [4:0]  d;
    logic [4:0]  base;
    logic [11:0] sum;
    logic        prefix;

    assign is_term = (character == CHAR_TERM);
    assign d       = digit_value(character);
    assign base    = cur.hex_mode ? BASE_HEX : BASE_DEC;
    assign sum     = cur.hex_mode
                   ? ({cur.accumulator, 4'b0000} + {7'd0, d})
                   : ({1'b0, cur.accumulator, 3'b000} + {3'b000, cur.accumulator, 1'b0}
                      + {7'd0, d});
    assign prefix  = (cur.char_count == 2'd1) && (character == CHAR_X)
                   && !cur.hex_mode && (cur.accumulator == 8'd0);

    always_comb
    begin
        nxt               = cur;
        result.status     = ST_SUCCESS;
        result.byte_value = 8'd0;
        if (is_term)
        begin
            nxt = '0;
            if (cur.char_count == 2'd0)
            begin
                result.status = ST_EMPTY;
            end
            else if (cur.first_error != ERR_NONE)
            begin
                result.status = cur.first_error;
            end
            else if (!cur.digits_seen)
            begin
                result.status = ST_INVALID;
            end
            else
            begin
                result.byte_value = cur.accumulator;
            end
        end
        else
        begin
            if (cur.char_count < COUNT_MAX)
            begin
                nxt.char_count = cur.char_count + 2'd1;
            end
            if (cur.first_error == ERR_NONE)
            begin
                if (prefix)
                begin
                    nxt.hex_mode    = 1'b1;
                    nxt.digits_seen = 1'b0;
                    nxt.accumulator = 8'd0;
                end
                else if (d >= base)
                begin
                    nxt.first_error = ST_INVALID;
                end
                else if (sum > BYTE_MAX)
                begin
                    nxt.first_error = ST_RANGE;
                end
                else
                begin
                    nxt.accumulator = sum[7:0];
                    nxt.digits_seen = 1'b1;
                end
            end
        end
    end

endmodule

### rtl/byte_literal_parser_top.sv
// Parses a decimal or 0x-prefixed hexadecimal byte literal fed one character per word,
// with a zero character closing the literal. One character is taken every cycle, except
// while a terminator waits for the output register; only the terminator produces an output
// word, which is registered in the output register once the terminator is processed. The
// per-character step (a multiply by 10 or 16 as shifts, an add and a range compare) sits
// between the input register and the parser state/output registers. The output register
// lets characters keep flowing while a result waits; only a terminator that finds the
// output still full holds the input side.
module byte_literal_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // character
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status[1:0], byte_value[9:2], zero fill
);
    import blp_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   in_char_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic         out_valid_reg;
    result_t      out_data_reg;
    result_t      step_result;
    logic         step_term;
    logic         out_free;
    logic         advance;

    blp_step u_step (
        .cur       (state_reg),
        .character (in_char_reg),
        .nxt       (state_next),
        .result    (step_result),
        .is_term   (step_term)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!step_term || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance && step_term)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_char_reg <= s_tdata;
        end
        if (advance && step_term)
        begin
            out_data_reg <= step_result;
        end
    end

`ifndef ASSERT_OFF
    a_clear_after_term: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_term) |=> (state_reg == '0))
        else $error("parser state not cleared after terminator");

    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.char_count != 2'd3)
        else $error("character count above saturation");

    a_value_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[1:0] != ST_SUCCESS)) |-> (m_tdata[9:2] == 8'd0))
        else $error("nonzero value with failing status");

    a_term_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && step_term && out_valid_reg && !m_tready) |-> !advance)
        else $error("terminator overwrote a pending result");
`endif

endmodule
